// ===== sv/sfcp_pkg.sv =====
`default_nettype none
package sfcp_pkg;

  localparam int ENTRIES  = 32;
  localparam int MAX_SEGS = 8;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int SEG_W    = $clog2(MAX_SEGS);
  localparam int NSEG_W   = SEG_W + 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  // byte counters: room for every entry charged at its largest
  localparam int BW       = 33 + CNT_W;

  localparam logic [31:0] CACHE_CAP_RST = 32'd65536;
  localparam logic [31:0] SEG_CAP_RST   = 32'd16384;
  localparam logic [4:0]  META_RST      = 5'd0;
  localparam logic [3:0]  SEGS_RST      = 4'd4;

  typedef enum logic [1:0] {
    CFG_CACHE_CAP = 2'd0,
    CFG_SEG_CAP   = 2'd1,
    CFG_META      = 2'd2,
    CFG_SEGS      = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ACT_ACCESS = 2'd0,
    ACT_PEEK   = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    K_HIT      = 3'd0,
    K_INSERTED = 3'd1,
    K_REJECTED = 3'd2,
    K_EVICT    = 3'd3,
    K_REMOVED  = 3'd4,
    K_NOTFOUND = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_SCAN,
    OP_LOAD_HIT,
    OP_LOAD_TAIL,
    OP_LOAD_EVICT,
    OP_UNLINK,
    OP_PUSH_LVL,
    OP_PUSH_DOWN,
    OP_RETIRE,
    OP_ALLOC,
    OP_LVL_UP,
    OP_SEG_ZERO,
    OP_INSERT,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    kind_t  kind;
    logic   last;
  } cmd_t;

  typedef struct packed {
    act_t action;
    logic found;
    logic match;
    logic scan_last;
    logic need_reject;
    logic over_cache;
    logic any_nonempty;
    logic full;
    logic no_free;
    logic fit;
    logic seg_last;
    logic hit_move;
    logic lvl_over;
    logic lvl_zero;
    logic lvl_top;
    logic out_free;
  } status_t;

  function automatic logic [BW-1:0] sat_sub(input logic [BW-1:0] a, input logic [BW-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

endpackage
`default_nettype wire

// ===== sv/sfcp_datapath.sv =====
`default_nettype none
module sfcp_datapath import sfcp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output status_t          status,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic [1:0]  in_action,
  input  wire logic [31:0] in_id,
  input  wire logic [31:0] in_size,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic [2:0]       out_kind,
  output logic [31:0]      out_id,
  output logic [31:0]      out_size,
  output logic             out_last
);

  // configuration
  logic [31:0] cache_cap;
  logic [31:0] seg_cap;
  logic [4:0]  meta;
  logic [3:0]  seg_use;

  // entry store and segment lists
  logic [31:0]      entry_key     [ENTRIES];
  logic [31:0]      entry_bytes   [ENTRIES];
  logic [SEG_W-1:0] entry_segment [ENTRIES];
  logic [IDX_W-1:0] entry_next    [ENTRIES];
  logic [IDX_W-1:0] entry_prev    [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;
  logic [IDX_W-1:0] seg_head  [MAX_SEGS];
  logic [IDX_W-1:0] seg_tail  [MAX_SEGS];
  logic [BW-1:0]    seg_bytes [MAX_SEGS];
  logic [CNT_W-1:0] seg_count [MAX_SEGS];
  logic [BW-1:0]    occupied;
  logic [CNT_W-1:0] object_count;

  // request and working registers
  act_t             req_action;
  logic [31:0]      req_id;
  logic [31:0]      req_size;
  logic [32:0]      need;
  logic [IDX_W-1:0] scan_idx;
  logic             found;
  logic [IDX_W-1:0] hit_e;
  logic [31:0]      hit_size;
  logic [IDX_W-1:0] cur_e;
  logic [31:0]      cur_key;
  logic [31:0]      cur_bytes;
  logic [SEG_W-1:0] cur_seg;
  logic [IDX_W-1:0] cur_prev;
  logic [IDX_W-1:0] cur_next;
  logic [32:0]      cur_charge;
  logic [SEG_W-1:0] lvl;
  logic [SEG_W-1:0] top;

  logic [NSEG_W-1:0] nseg;
  logic [SEG_W-1:0]  sa;
  logic [IDX_W-1:0]  rd_e;
  logic [SEG_W-1:0]  low_seg;
  logic              any_ne;
  logic [IDX_W-1:0]  free_e;
  logic              free_ok;
  logic [BW-1:0]     sb;
  logic [CNT_W-1:0]  sc;
  logic [IDX_W-1:0]  sh;
  logic [BW-1:0]     chg;

  always_comb begin
    if (seg_use == '0) begin
      nseg = NSEG_W'(1);
    end else if (seg_use > 4'(MAX_SEGS)) begin
      nseg = NSEG_W'(MAX_SEGS);
    end else begin
      nseg = NSEG_W'(seg_use);
    end
  end

  always_comb begin
    case (cmd.op)
      OP_UNLINK:     sa = cur_seg;
      OP_PUSH_DOWN:  sa = lvl - SEG_W'(1);
      OP_LOAD_EVICT: sa = low_seg;
      default:       sa = lvl;
    endcase
  end

  always_comb begin
    case (cmd.op)
      OP_SCAN:     rd_e = scan_idx;
      OP_LOAD_HIT: rd_e = hit_e;
      default:     rd_e = seg_tail[sa];
    endcase
  end

  // lowest non-empty segment and first free slot
  always_comb begin
    low_seg = '0;
    any_ne  = 1'b0;
    for (int s = MAX_SEGS - 1; s >= 0; s--) begin
      if (seg_count[s] != '0) begin
        low_seg = SEG_W'(s);
        any_ne  = 1'b1;
      end
    end
  end

  always_comb begin
    free_e  = '0;
    free_ok = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        free_e  = IDX_W'(i);
        free_ok = 1'b1;
      end
    end
  end

  assign sb  = seg_bytes[sa];
  assign sc  = seg_count[sa];
  assign sh  = seg_head[sa];
  assign chg = BW'(cur_charge);

  always_comb begin
    status.action       = req_action;
    status.found        = found;
    status.match        = entry_valid[scan_idx] && (entry_key[scan_idx] == req_id);
    status.scan_last    = (scan_idx == IDX_W'(ENTRIES - 1));
    status.need_reject  = (need > {1'b0, seg_cap}) || (need > {1'b0, cache_cap});
    status.over_cache   = ({1'b0, occupied} + (BW+1)'(need)) > (BW+1)'(cache_cap);
    status.any_nonempty = any_ne;
    status.full         = (object_count >= CNT_W'(ENTRIES));
    status.no_free      = !free_ok;
    status.fit          = ({1'b0, sb} + (BW+1)'(need)) <= (BW+1)'(seg_cap);
    status.seg_last     = ({1'b0, lvl} + NSEG_W'(1)) >= nseg;
    status.hit_move     = (req_action == ACT_ACCESS) && (({1'b0, cur_seg} + NSEG_W'(1)) < nseg);
    status.lvl_over     = (sb > BW'(seg_cap)) && (sc != '0);
    status.lvl_zero     = (lvl == '0);
    status.lvl_top      = (lvl == top);
    status.out_free     = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_cap    <= CACHE_CAP_RST;
      seg_cap      <= SEG_CAP_RST;
      meta         <= META_RST;
      seg_use      <= SEGS_RST;
      entry_valid  <= '0;
      occupied     <= '0;
      object_count <= '0;
      found        <= 1'b0;
      out_valid    <= 1'b0;
      for (int s = 0; s < MAX_SEGS; s++) begin
        seg_bytes[s] <= '0;
        seg_count[s] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_CACHE_CAP: cache_cap <= cfg_data;
          CFG_SEG_CAP:   seg_cap   <= cfg_data;
          CFG_META:      meta      <= cfg_data[4:0];
          CFG_SEGS:      seg_use   <= cfg_data[3:0];
          default:       ;
        endcase
      end

      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (cmd.op)
        OP_CAPTURE: begin
          req_action <= act_t'(in_action);
          req_id     <= in_id;
          req_size   <= in_size;
          need       <= {1'b0, in_size} + 33'(meta);
          scan_idx   <= '0;
          found      <= 1'b0;
        end
        OP_SCAN: begin
          if (entry_valid[scan_idx] && (entry_key[scan_idx] == req_id)) begin
            found <= 1'b1;
            hit_e <= scan_idx;
          end
          scan_idx <= scan_idx + IDX_W'(1);
        end
        OP_LOAD_HIT, OP_LOAD_TAIL, OP_LOAD_EVICT: begin
          cur_e      <= rd_e;
          cur_key    <= entry_key[rd_e];
          cur_bytes  <= entry_bytes[rd_e];
          cur_seg    <= entry_segment[rd_e];
          cur_prev   <= entry_prev[rd_e];
          cur_next   <= entry_next[rd_e];
          cur_charge <= {1'b0, entry_bytes[rd_e]} + 33'(meta);
          if (cmd.op == OP_LOAD_HIT) begin
            hit_size <= entry_bytes[rd_e];
            lvl      <= entry_segment[rd_e] + SEG_W'(1);
            top      <= entry_segment[rd_e] + SEG_W'(1);
          end
        end
        OP_UNLINK: begin
          if (seg_head[sa] == cur_e) begin
            seg_head[sa] <= cur_next;
          end else begin
            entry_next[cur_prev] <= cur_next;
          end
          if (seg_tail[sa] == cur_e) begin
            seg_tail[sa] <= cur_prev;
          end else begin
            entry_prev[cur_next] <= cur_prev;
          end
          if (sc != '0) begin
            seg_count[sa] <= sc - CNT_W'(1);
          end
          seg_bytes[sa] <= sat_sub(sb, chg);
        end
        OP_PUSH_LVL, OP_PUSH_DOWN, OP_INSERT: begin
          entry_segment[cur_e] <= sa;
          entry_prev[cur_e]    <= cur_e;
          if (sc == '0) begin
            entry_next[cur_e] <= cur_e;
            seg_tail[sa]      <= cur_e;
          end else begin
            entry_next[cur_e] <= sh;
            entry_prev[sh]    <= cur_e;
          end
          seg_head[sa]  <= cur_e;
          seg_count[sa] <= sc + CNT_W'(1);
          seg_bytes[sa] <= sb + chg;
          if (cmd.op == OP_PUSH_DOWN) begin
            lvl <= lvl - SEG_W'(1);
          end
          if (cmd.op == OP_INSERT) begin
            entry_key[cur_e]   <= req_id;
            entry_bytes[cur_e] <= req_size;
            entry_valid[cur_e] <= 1'b1;
            object_count       <= object_count + CNT_W'(1);
            occupied           <= occupied + chg;
          end
        end
        OP_RETIRE: begin
          occupied           <= sat_sub(occupied, chg);
          entry_valid[cur_e] <= 1'b0;
          if (object_count != '0) begin
            object_count <= object_count - CNT_W'(1);
          end
        end
        OP_ALLOC: begin
          cur_e      <= free_e;
          cur_charge <= need;
          lvl        <= '0;
        end
        OP_LVL_UP: begin
          lvl <= lvl + SEG_W'(1);
        end
        OP_SEG_ZERO: begin
          lvl <= '0;
        end
        OP_EMIT: begin
          out_kind <= cmd.kind;
          out_last <= cmd.last;
          out_id   <= (cmd.kind == K_EVICT) ? cur_key : req_id;
          case (cmd.kind)
            K_HIT:                  out_size <= hit_size;
            K_INSERTED, K_REJECTED: out_size <= req_size;
            K_EVICT, K_REMOVED:     out_size <= cur_bytes;
            default:                out_size <= '0;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/sfcp_ctrl.sv =====
`default_nettype none
module sfcp_ctrl import sfcp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [23:0] {
    S_IDLE      = 24'h000001,
    S_SCAN      = 24'h000002,
    S_DECIDE    = 24'h000004,
    S_RM_LOAD   = 24'h000008,
    S_RM_UNLINK = 24'h000010,
    S_RM_RETIRE = 24'h000020,
    S_HIT_LOAD  = 24'h000040,
    S_HIT_CHK   = 24'h000080,
    S_HIT_UNLNK = 24'h000100,
    S_HIT_PUSH  = 24'h000200,
    S_CASC      = 24'h000400,
    S_CL_LOAD   = 24'h000800,
    S_CL_UNLINK = 24'h001000,
    S_CL_PUSH   = 24'h002000,
    S_INS_LOOP  = 24'h004000,
    S_INS_FULL  = 24'h008000,
    S_ALLOC     = 24'h010000,
    S_SEGSCAN   = 24'h020000,
    S_INS       = 24'h040000,
    S_EV_LOAD   = 24'h080000,
    S_EV_UNLINK = 24'h100000,
    S_EV_RETIRE = 24'h200000,
    S_EV_EMIT   = 24'h400000,
    S_FINAL     = 24'h800000
  } state_t;

  typedef enum logic [1:0] {
    RET_CASC,
    RET_LOOP,
    RET_ALLOC
  } ret_t;

  state_t state, state_next;
  ret_t   ret, ret_next;
  kind_t  final_kind, final_kind_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next      = state;
    ret_next        = ret;
    final_kind_next = final_kind;
    cmd.op          = OP_NOP;
    cmd.kind        = K_HIT;
    cmd.last        = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_CAPTURE;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.action == ACT_NONE) begin
          state_next = S_IDLE;
        end else begin
          cmd.op = OP_SCAN;
          if (status.match || status.scan_last) begin
            state_next = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        if (status.action == ACT_REMOVE) begin
          if (status.found) begin
            state_next = S_RM_LOAD;
          end else begin
            final_kind_next = K_NOTFOUND;
            state_next      = S_FINAL;
          end
        end else if (status.found) begin
          state_next = S_HIT_LOAD;
        end else if (status.action == ACT_PEEK || status.need_reject) begin
          final_kind_next = K_REJECTED;
          state_next      = S_FINAL;
        end else begin
          state_next = S_INS_LOOP;
        end
      end
      S_RM_LOAD: begin
        cmd.op     = OP_LOAD_HIT;
        state_next = S_RM_UNLINK;
      end
      S_RM_UNLINK: begin
        cmd.op     = OP_UNLINK;
        state_next = S_RM_RETIRE;
      end
      S_RM_RETIRE: begin
        cmd.op          = OP_RETIRE;
        final_kind_next = K_REMOVED;
        state_next      = S_FINAL;
      end
      S_HIT_LOAD: begin
        cmd.op     = OP_LOAD_HIT;
        state_next = S_HIT_CHK;
      end
      S_HIT_CHK: begin
        if (status.hit_move) begin
          state_next = S_HIT_UNLNK;
        end else begin
          final_kind_next = K_HIT;
          state_next      = S_FINAL;
        end
      end
      S_HIT_UNLNK: begin
        cmd.op     = OP_UNLINK;
        state_next = S_HIT_PUSH;
      end
      S_HIT_PUSH: begin
        cmd.op     = OP_PUSH_LVL;
        state_next = S_CASC;
      end
      S_CASC: begin
        if (status.lvl_over) begin
          if (status.lvl_zero) begin
            ret_next   = RET_CASC;
            state_next = S_EV_LOAD;
          end else begin
            state_next = S_CL_LOAD;
          end
        end else if (status.lvl_top) begin
          final_kind_next = K_HIT;
          state_next      = S_FINAL;
        end else begin
          cmd.op = OP_LVL_UP;
        end
      end
      S_CL_LOAD: begin
        cmd.op     = OP_LOAD_TAIL;
        state_next = S_CL_UNLINK;
      end
      S_CL_UNLINK: begin
        cmd.op     = OP_UNLINK;
        state_next = S_CL_PUSH;
      end
      S_CL_PUSH: begin
        cmd.op     = OP_PUSH_DOWN;
        state_next = S_CASC;
      end
      S_INS_LOOP: begin
        if (status.over_cache && status.any_nonempty) begin
          ret_next   = RET_LOOP;
          state_next = S_EV_LOAD;
        end else begin
          state_next = S_INS_FULL;
        end
      end
      S_INS_FULL: begin
        if (status.full && status.any_nonempty) begin
          ret_next   = RET_ALLOC;
          state_next = S_EV_LOAD;
        end else begin
          state_next = S_ALLOC;
        end
      end
      S_ALLOC: begin
        cmd.op = OP_ALLOC;
        if (status.no_free) begin
          final_kind_next = K_REJECTED;
          state_next      = S_FINAL;
        end else begin
          state_next = S_SEGSCAN;
        end
      end
      S_SEGSCAN: begin
        if (status.fit) begin
          state_next = S_INS;
        end else if (status.seg_last) begin
          cmd.op     = OP_SEG_ZERO;
          state_next = S_INS;
        end else begin
          cmd.op = OP_LVL_UP;
        end
      end
      S_INS: begin
        cmd.op          = OP_INSERT;
        final_kind_next = K_INSERTED;
        state_next      = S_FINAL;
      end
      S_EV_LOAD: begin
        cmd.op     = OP_LOAD_EVICT;
        state_next = S_EV_UNLINK;
      end
      S_EV_UNLINK: begin
        cmd.op     = OP_UNLINK;
        state_next = S_EV_RETIRE;
      end
      S_EV_RETIRE: begin
        cmd.op     = OP_RETIRE;
        state_next = S_EV_EMIT;
      end
      S_EV_EMIT: begin
        if (status.out_free) begin
          cmd.op   = OP_EMIT;
          cmd.kind = K_EVICT;
          case (ret)
            RET_CASC: state_next = S_CASC;
            RET_LOOP: state_next = S_INS_LOOP;
            default:  state_next = S_ALLOC;
          endcase
        end
      end
      S_FINAL: begin
        if (status.out_free) begin
          cmd.op     = OP_EMIT;
          cmd.kind   = final_kind;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= RET_CASC;
      final_kind <= K_HIT;
    end else begin
      state      <= state_next;
      ret        <= ret_next;
      final_kind <= final_kind_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/segmented_fifo_cache_policy_top.sv =====
// Segmented FIFO object cache replacement engine.
// Input channel (in_valid/in_ready) takes one request transaction: action
// (access, peek, remove), obj_id and obj_bytes. Output channel
// (out_valid/out_ready) delivers result transactions: evictions first, in
// the order they happen, then the request's own result with last set.
// Configuration channel (cfg_valid/cfg_ready, ready whenever out of reset)
// writes the cache capacity, segment capacity, metadata charge and segment
// count; write only while no request is in flight.
// One request at a time; in_ready is high only in the idle state. The key
// lookup walks the 32 entries one a cycle, stopping at the first match, and
// an insertion probes the segments in turn from the lowest. The next request
// is taken once the sequencer has handed its final result to the output
// register; an ignored action gives no result.
// Results leave through a single output register; if the receiver stalls
// the sequencer waits at the next emit and resumes as soon as the
// register drains. Reset (synchronous) empties the cache, zeroes the
// segment counters and restores the register defaults.
`default_nettype none
module segmented_fifo_cache_policy_top import sfcp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [31:0] obj_id,
  input  wire logic [31:0] obj_bytes,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       kind,
  output logic [31:0]      result_id,
  output logic [31:0]      result_size,
  output logic             last
);

  cmd_t    cmd;
  status_t status;

  // registers are plain flops, a write lands on any cycle out of reset
  assign cfg_ready = !rst;

  sfcp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sfcp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_action (action),
    .in_id     (obj_id),
    .in_size   (obj_bytes),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_kind  (kind),
    .out_id    (result_id),
    .out_size  (result_size),
    .out_last  (last)
  );

  // a new request transaction always leaves the idle state
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted but sequencer still idle");

  // only evictions are followed by further results of the same request
  a_last_marks_final: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (kind != K_EVICT)))
    else $error("last flag disagrees with result kind");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind <= K_NOTFOUND))
    else $error("result kind out of range");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending straight after reset");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
// Segmented cache engine bench: a behavioural copy of the replacement policy
// predicts each request's result transactions; the outcome log checks them
// in order as they leave the block.
module tb;
  import sfcp_pkg::*;

  typedef struct {
    kind_t       k;
    logic [31:0] id;
    logic [31:0] sz;
    logic        lst;
  } outcome_t;

  // Scoreboard: holds predicted outcomes, compares delivered ones in order.
  class outcome_log;
    outcome_t pending[$];
    int       errors;

    function void note(outcome_t o);
      pending.push_back(o);
    endfunction

    function void check(logic [2:0] k, logic [31:0] id, logic [31:0] sz, logic lst);
      outcome_t o;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result kind=%0d id=%h", k, id);
        return;
      end
      o = pending.pop_front();
      if (k !== o.k || id !== o.id || sz !== o.sz || lst !== o.lst) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp k=%0d id=%h sz=%h l=%0b got k=%0d id=%h sz=%h l=%0b",
                   o.k, o.id, o.sz, o.lst, k, id, sz, lst);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = '0;
  logic [31:0] obj_id = '0;
  logic [31:0] obj_bytes = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [31:0] result_id;
  logic [31:0] result_size;
  logic        last;

  segmented_fifo_cache_policy_top dut (.*);

  initial forever #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Policy state mirror. Byte counters are 64 bits so no sum can wrap.
  // ---------------------------------------------------------------------
  logic [31:0] cap_total, cap_seg;
  logic [4:0]  meta;
  logic [3:0]  nseg_reg;
  logic [31:0] e_key[ENTRIES];
  logic [31:0] e_sz[ENTRIES];
  int          e_seg[ENTRIES];
  bit          e_on[ENTRIES];
  int          e_nxt[ENTRIES];
  int          e_prv[ENTRIES];
  int          s_head[MAX_SEGS];
  int          s_tail[MAX_SEGS];
  longint unsigned s_bytes[MAX_SEGS];
  int          s_cnt[MAX_SEGS];
  longint unsigned used_bytes;
  int          n_obj;
  outcome_t    burst[$];   // outcomes of the request being predicted

  outcome_log log_h;

  // ids sent with access requests, used to aim hits
  logic [31:0] live_ids[$];

  function automatic longint unsigned dec_sat(longint unsigned a, longint unsigned b);
    return a > b ? a - b : 0;
  endfunction

  function automatic longint unsigned cost(int e);
    return longint'(e_sz[e]) + meta;
  endfunction

  function automatic void add_out(kind_t k, logic [31:0] id, logic [31:0] sz);
    outcome_t o;
    o.k = k; o.id = id; o.sz = sz; o.lst = 1'b0;
    burst.push_back(o);
  endfunction

  function automatic void detach(int e);
    int s, p, n;
    s = e_seg[e]; p = e_prv[e]; n = e_nxt[e];
    if (s_head[s] == e) s_head[s] = n; else e_nxt[p] = n;
    if (s_tail[s] == e) s_tail[s] = p; else e_prv[n] = p;
    if (s_cnt[s] > 0) s_cnt[s]--;
    s_bytes[s] = dec_sat(s_bytes[s], cost(e));
  endfunction

  function automatic void attach(int e, int s);
    e_seg[e] = s;
    e_prv[e] = e;
    if (s_cnt[s] == 0) begin
      e_nxt[e] = e;
      s_tail[s] = e;
    end else begin
      e_nxt[e] = s_head[s];
      e_prv[s_head[s]] = e;
    end
    s_head[s] = e;
    s_cnt[s]++;
    s_bytes[s] += cost(e);
  endfunction

  function automatic bit drop_coldest();
    int s, e;
    for (s = 0; s < MAX_SEGS; s++) if (s_cnt[s] > 0) break;
    if (s >= MAX_SEGS) return 0;
    e = s_tail[s];
    detach(e);
    used_bytes = dec_sat(used_bytes, cost(e));
    e_on[e] = 0;
    if (n_obj > 0) n_obj--;
    add_out(K_EVICT, e_key[e], e_sz[e]);
    return 1;
  endfunction

  function automatic void demote(int s);
    int e;
    if (s_cnt[s] == 0) return;
    if (s == 0) begin
      void'(drop_coldest());
      return;
    end
    e = s_tail[s];
    detach(e);
    attach(e, s - 1);
    while (s_bytes[s-1] > cap_seg && s_cnt[s-1] > 0) demote(s - 1);
  endfunction

  function automatic void clear_policy();
    cap_total = CACHE_CAP_RST; cap_seg = SEG_CAP_RST; meta = META_RST; nseg_reg = SEGS_RST;
    foreach (e_on[i]) e_on[i] = 0;
    foreach (s_cnt[i]) begin s_cnt[i] = 0; s_bytes[i] = 0; end
    used_bytes = 0; n_obj = 0;
  endfunction

  // Predict the outcomes of one request and hand them to the log.
  function automatic void predict_request(act_t a, logic [31:0] id, logic [31:0] sz);
    int nseg, e, s, slot;
    longint unsigned need;
    logic [31:0] hs;
    burst.delete();
    if (a == ACT_NONE) return;
    nseg = nseg_reg == 0 ? 1 : (nseg_reg > MAX_SEGS ? MAX_SEGS : nseg_reg);
    e = -1;
    for (int i = 0; i < ENTRIES; i++) if (e_on[i] && e_key[i] == id) begin e = i; break; end
    if (a == ACT_REMOVE) begin
      if (e < 0) add_out(K_NOTFOUND, id, '0);
      else begin
        detach(e);
        used_bytes = dec_sat(used_bytes, cost(e));
        e_on[e] = 0;
        if (n_obj > 0) n_obj--;
        add_out(K_REMOVED, id, e_sz[e]);
      end
    end else if (e >= 0) begin
      hs = e_sz[e];
      s = e_seg[e];
      if (a == ACT_ACCESS && s + 1 < nseg) begin
        detach(e);
        attach(e, s + 1);
        while (s_bytes[s+1] > cap_seg && s_cnt[s+1] > 0) demote(s + 1);
      end
      add_out(K_HIT, id, hs);
    end else if (a == ACT_PEEK) begin
      add_out(K_REJECTED, id, sz);
    end else begin
      need = longint'(sz) + meta;
      if (need > cap_seg || need > cap_total) add_out(K_REJECTED, id, sz);
      else begin
        while (used_bytes + need > cap_total) if (!drop_coldest()) break;
        if (n_obj >= ENTRIES) void'(drop_coldest());
        for (slot = 0; slot < ENTRIES; slot++) if (!e_on[slot]) break;
        if (slot < ENTRIES) begin
          for (s = 0; s < nseg; s++) if (s_bytes[s] + need <= cap_seg) break;
          if (s >= nseg) s = 0;
          e_key[slot] = id; e_sz[slot] = sz; e_on[slot] = 1;
          attach(slot, s);
          n_obj++;
          used_bytes += need;
          add_out(K_INSERTED, id, sz);
        end else add_out(K_REJECTED, id, sz);
      end
    end
    burst[burst.size()-1].lst = 1'b1;
    foreach (burst[i]) log_h.note(burst[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Drivers and monitor
  // ---------------------------------------------------------------------
  bit quiet;        // no idling at all in the closing stretch
  int idle_in;      // remaining idle cycles on the request side
  int stall_out;    // remaining stall cycles on the result side
  int dry_cycles;   // cycles without any transaction
  localparam int WATCHDOG = 20000;

  // valid drops after each transaction; the block is busy then
  task automatic send_request(act_t a, logic [31:0] id, logic [31:0] sz);
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 13)) @(posedge clk);
    action <= a; obj_id <= id; obj_bytes <= sz; in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_request(a, id, sz);
    if (a == ACT_ACCESS) live_ids.push_back(id);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t r, logic [31:0] v);
    cfg_index <= r; cfg_data <= v; cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (r)
      CFG_CACHE_CAP: cap_total = v;
      CFG_SEG_CAP:   cap_seg = v;
      CFG_META:      meta = v[4:0];
      default:       nseg_reg = v[3:0];
    endcase
    @(posedge clk);
  endtask

  // wait for the block to go quiet before touching registers
  task automatic drain();
    while (log_h.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // result side: random stall bursts, none once quiet
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_out = 0;
    end else begin
      if (out_valid && out_ready) log_h.check(kind, result_id, result_size, last);
      if (stall_out > 0) stall_out--;
      else if (!quiet && $urandom_range(0, 9) == 0) stall_out = $urandom_range(1, 13);
      out_ready <= (stall_out == 0);
    end
  end

  // watchdog: too long with nothing moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || rst)
      dry_cycles = 0;
    else dry_cycles++;
    if (dry_cycles >= WATCHDOG) begin
      $display("[segmented_fifo_cache_policy_top] ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] pick_id();
    if (live_ids.size() > 0 && $urandom_range(0, 1))
      return live_ids[$urandom_range(0, live_ids.size() - 1)];
    return $urandom_range(0, 1) ? $urandom_range(0, 47) : $urandom;
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return $urandom;          // mostly rejected
      2: return cap_seg;           // fits only with zero metadata
      default: return $urandom_range(1, 3000);
    endcase
  endfunction

  task automatic random_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r < 11) send_request(ACT_ACCESS, pick_id(), pick_size());
      else if (r < 15) send_request(ACT_PEEK, pick_id(), $urandom);
      else if (r < 19) send_request(ACT_REMOVE, pick_id(), $urandom);
      else send_request(ACT_NONE, $urandom, $urandom);
    end
  endtask

  initial begin
    log_h = new();
    clear_policy();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every action, extreme fields, cascade and full-slot cases
    send_request(ACT_PEEK, 32'h0, 32'h0);                 // peek miss
    send_request(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0);       // remove absent
    send_request(ACT_ACCESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // too large
    send_request(ACT_ACCESS, 32'h0, 32'h0);               // zero-byte object
    send_request(ACT_ACCESS, 32'h0, 32'h5);               // hit, promote
    send_request(ACT_PEEK, 32'h0, 32'h0);
    send_request(ACT_NONE, 32'h0, 32'h0);                 // ignored
    for (int i = 1; i <= 8; i++) send_request(ACT_ACCESS, i, 32'd9000);
    for (int i = 1; i <= 6; i++) send_request(ACT_ACCESS, i, 32'd0); // hit cascades
    send_request(ACT_REMOVE, 32'h0, 32'h0);
    drain();

    // tight cache, many zero-byte objects fill every slot
    write_reg(CFG_CACHE_CAP, 32'd1);
    write_reg(CFG_SEG_CAP, 32'd1);
    write_reg(CFG_SEGS, 32'd8);
    write_reg(CFG_META, 32'd16);
    random_phase(20);
    drain();
    write_reg(CFG_META, 32'd0);
    for (int i = 0; i < 36; i++) send_request(ACT_ACCESS, 32'h100 + i, 32'd0);
    random_phase(40);
    drain();

    // wide open, odd segment counts, metadata changed with objects resident
    write_reg(CFG_CACHE_CAP, 32'hFFFF_FFFF);
    write_reg(CFG_SEG_CAP, 32'hFFFF_FFFF);
    write_reg(CFG_SEGS, 32'd0);
    random_phase(50);
    drain();
    write_reg(CFG_META, 32'd31);
    write_reg(CFG_SEGS, 32'd15);
    write_reg(CFG_CACHE_CAP, 32'd12000);
    write_reg(CFG_SEG_CAP, 32'd3000);
    random_phase(50);
    drain();                        // sender waits for every result here
    write_reg(CFG_SEGS, 32'd2);     // objects stranded above active segments
    write_reg(CFG_META, 32'd16);
    random_phase(50);
    drain();

    // defaults again, closing stretch without idling
    write_reg(CFG_CACHE_CAP, CACHE_CAP_RST);
    write_reg(CFG_SEG_CAP, SEG_CAP_RST);
    write_reg(CFG_META, META_RST);
    write_reg(CFG_SEGS, SEGS_RST);
    random_phase(30);
    quiet = 1;
    random_phase(35);

    while (log_h.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (log_h.errors == 0) $display("[segmented_fifo_cache_policy_top] OK");
    else $display("[segmented_fifo_cache_policy_top] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
